>>> src/iqm_pkg.sv
// Shared types and constants of the ADC frame interquartile mean block.
// Used by the divider, the datapath, the controller and the top level.
`default_nettype none
package iqm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int GROUP_SAMPLES = 4;
   localparam int SUM_W = 14;
   localparam int DIVIDEND_W = 24;
   localparam int DIVISOR_W = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_COLD  = 3'd0,
      CSR_CAL_HOT   = 3'd1,
      CSR_COLD_TEMP = 3'd2,
      CSR_HOT_TEMP  = 3'd3,
      CSR_VREF_NUM  = 3'd4,
      CSR_CONV_SCL  = 3'd5
   } csr_index_type;

   typedef enum logic {
      DIV_SEL_TEMP = 1'b0,
      DIV_SEL_VOLT = 1'b1
   } div_sel_type;

   typedef struct packed {
      logic        insert;
      logic        acc_temp;
      logic        acc_ref;
      logic        shift;
      logic        sum_en;
      logic        prep;
      logic        div_start;
      div_sel_type div_sel;
      logic        mul;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage
`default_nettype wire

>>> src/adc_frame_iqm_temperature_top.sv
// Top level of the ADC frame interquartile mean and temperature block.
// Depends on iqm_pkg, iqm_ctrl, iqm_dp and iqm_div.
`default_nettype none
// Each frame is SENSOR_SAMPLES sensor samples, four temperature samples and
// four reference samples. While the frame is collected a sample is taken in
// every cycle that offers one; each sensor sample is sorted into a row of
// cells on arrival. After the last sample the input is held off: the block
// reads out the sorted row, forms the interquartile mean and the temperature
// operands, runs two divisions on one shared divider, multiplies and loads
// the result. A finished result waits in its output register while the next
// frame is collected; if it is still waiting when the next result is ready,
// the block stalls until it is taken.
module adc_frame_iqm_temperature_top #(
   parameter int SENSOR_SAMPLES = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [15:0]                       req_tdata,  // sample
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // sensor_mean, temp_mean, ref_mean, temperature, voltage, cal_invalid, ref_zero
   output logic [iqm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [iqm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [iqm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import iqm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   iqm_ctrl #(.SENSOR_SAMPLES(SENSOR_SAMPLES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   iqm_dp #(.SENSOR_SAMPLES(SENSOR_SAMPLES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sample    (req_tdata[SAMPLE_W-1:0]),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> src/iqm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses iqm_pkg for the operand widths.
`default_nettype none
module iqm_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [iqm_pkg::DIVIDEND_W-1:0]  dividend,
   input  wire logic [iqm_pkg::DIVISOR_W-1:0]   divisor,
   output logic                                 done,
   output logic [iqm_pkg::DIVIDEND_W-1:0]       quotient
);
   import iqm_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> src/iqm_dp.sv
// Datapath: configuration registers, insertion-sorting cell row, group sums,
// shared divider, multiplier and result register. Uses iqm_pkg and iqm_div.
`default_nettype none
module iqm_dp #(
   parameter int SENSOR_SAMPLES = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [iqm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [iqm_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic [iqm_pkg::SAMPLE_W-1:0]      sample,
   input  wire iqm_pkg::dp_cmd_type               cmd,
   output iqm_pkg::dp_status_type                 status,
   output logic [iqm_pkg::RSP_DATA_W-1:0]         rsp_data
);
   import iqm_pkg::*;

   localparam int N_W = $clog2(SENSOR_SAMPLES + 1);
   localparam int IQ_W = SAMPLE_W + N_W;
   localparam int HALF = SENSOR_SAMPLES / 2;
   localparam int RECIP_SH = IQ_W + $clog2(HALF);
   localparam int PROD_W = RECIP_SH + IQ_W;
   localparam longint RECIP_M =
      ((longint'(1) << RECIP_SH) + longint'(HALF) - 1) / longint'(HALF);

   logic [11:0]         cal_cold_ff, cal_hot_ff;
   logic [7:0]          cold_temp_ff, hot_temp_ff;
   logic [23:0]         vref_ff;
   logic [15:0]         scale_ff;

   logic [SAMPLE_W-1:0] cell_ff [SENSOR_SAMPLES];
   logic [SAMPLE_W-1:0] cell_in [SENSOR_SAMPLES];
   logic [SENSOR_SAMPLES-1:0] gt;
   logic [N_W-1:0]      count_ff;
   logic [SUM_W-1:0]    temp_sum_ff, ref_sum_ff;
   logic [IQ_W-1:0]     iq_sum_ff;

   logic                num_neg_ff, den_neg_ff, cal_bad_ff;
   logic [20:0]         num_mag_ff;
   logic [11:0]         den_mag_ff;
   logic [11:0]         sensor_mean_ff;
   logic signed [15:0]  temp_ff;
   logic [23:0]         vq_ff;
   logic [39:0]         prod_ff;

   logic [11:0]         tm, rm;
   logic signed [12:0]  dt, den;
   logic signed [8:0]   dtemp;
   logic signed [21:0]  num;
   logic [21:0]         num_abs;
   logic [12:0]         den_abs;
   logic [PROD_W-1:0]   iq_prod;
   logic [IQ_W-1:0]     iq_quo;
   logic [DIVIDEND_W-1:0] div_a;
   logic [DIVISOR_W-1:0]  div_b;
   logic                div_done;
   logic [DIVIDEND_W-1:0] quo;
   div_sel_type         sel_ff;
   logic signed [22:0]  q_s, t_s;
   logic [15:0]         volt;

   assign tm = temp_sum_ff[SUM_W-1:2];
   assign rm = ref_sum_ff[SUM_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cold_ff  <= 12'd680;
         cal_hot_ff   <= 12'd856;
         cold_temp_ff <= 8'd30;
         hot_temp_ff  <= 8'd110;
         vref_ff      <= '0;
         scale_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAL_COLD:  cal_cold_ff  <= csr_data[11:0];
            CSR_CAL_HOT:   cal_hot_ff   <= csr_data[11:0];
            CSR_COLD_TEMP: cold_temp_ff <= csr_data[7:0];
            CSR_HOT_TEMP:  hot_temp_ff  <= csr_data[7:0];
            CSR_VREF_NUM:  vref_ff      <= csr_data[23:0];
            CSR_CONV_SCL:  scale_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Each cell compares the new sample with its own value; the row stays sorted.
   always_comb begin
      for (int k = 0; k < SENSOR_SAMPLES; k++) begin
         gt[k] = (k < int'(count_ff)) && (cell_ff[k] > sample);
      end
      for (int k = 0; k < SENSOR_SAMPLES; k++) begin
         cell_in[k] = cell_ff[k];
         if (cmd.shift) begin
            cell_in[k] = (k == SENSOR_SAMPLES - 1) ? '0 : cell_ff[(k + 1) % SENSOR_SAMPLES];
         end else if (cmd.insert && (gt[k] || k == int'(count_ff))) begin
            if (k > 0 && gt[(k + SENSOR_SAMPLES - 1) % SENSOR_SAMPLES]) begin
               cell_in[k] = cell_ff[(k + SENSOR_SAMPLES - 1) % SENSOR_SAMPLES];
            end else begin
               cell_in[k] = sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SENSOR_SAMPLES; k++) begin
         cell_ff[k] <= cell_in[k];
      end
      if (reset || cmd.shift) begin
         count_ff <= '0;
      end else if (cmd.insert) begin
         count_ff <= N_W'(count_ff + 1'b1);
      end
      if (reset || cmd.load_out) begin
         temp_sum_ff <= '0;
         ref_sum_ff  <= '0;
         iq_sum_ff   <= '0;
      end else begin
         if (cmd.acc_temp) temp_sum_ff <= SUM_W'(temp_sum_ff + sample);
         if (cmd.acc_ref)  ref_sum_ff  <= SUM_W'(ref_sum_ff + sample);
         if (cmd.sum_en)   iq_sum_ff   <= IQ_W'(iq_sum_ff + cell_ff[0]);
      end
   end

   // The middle sum is divided by the constant half count through a reciprocal product.
   assign iq_prod = PROD_W'(iq_sum_ff) * PROD_W'(RECIP_M);
   assign iq_quo  = iq_prod[RECIP_SH +: IQ_W];

   always_comb begin
      dt      = $signed({1'b0, tm}) - $signed({1'b0, cal_cold_ff});
      dtemp   = $signed({hot_temp_ff[7], hot_temp_ff}) - $signed({cold_temp_ff[7], cold_temp_ff});
      num     = dt * dtemp;
      num_abs = num[21] ? 22'(-num) : 22'(num);
      den     = $signed({1'b0, cal_hot_ff}) - $signed({1'b0, cal_cold_ff});
      den_abs = den[12] ? 13'(-den) : 13'(den);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         sensor_mean_ff <= (iq_quo > IQ_W'(4095)) ? 12'hFFF : iq_quo[11:0];
         num_neg_ff     <= num[21];
         num_mag_ff     <= num_abs[20:0];
         den_neg_ff     <= den[12];
         den_mag_ff     <= den_abs[11:0];
         cal_bad_ff     <= (den == 13'sd0);
      end
      if (cmd.div_start) begin
         sel_ff <= cmd.div_sel;
      end
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_TEMP: begin
            div_a = DIVIDEND_W'(num_mag_ff);
            div_b = den_mag_ff;
         end
         default: begin
            div_a = vref_ff;
            div_b = rm;
         end
      endcase
   end

   iqm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (quo)
   );

   assign status.div_done = div_done;

   always_comb begin
      q_s = $signed({2'b00, quo[20:0]});
      t_s = (num_neg_ff ^ den_neg_ff) ? -q_s : q_s;
      t_s = t_s + 23'($signed(cold_temp_ff));
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (sel_ff)
            DIV_SEL_TEMP: begin
               if (cal_bad_ff)                temp_ff <= '0;
               else if (t_s > 23'sd32767)     temp_ff <= 16'sh7FFF;
               else if (t_s < -23'sd32768)    temp_ff <= 16'sh8000;
               else                           temp_ff <= t_s[15:0];
            end
            default: vq_ff <= quo;
         endcase
      end
      if (cmd.mul) begin
         prod_ff <= vq_ff * scale_ff;
      end
   end

   assign volt = (rm == '0) ? '0 : ((prod_ff > 40'd65535) ? 16'hFFFF : prod_ff[15:0]);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data <= {2'b00, (rm == '0), cal_bad_ff, volt, temp_ff, rm, tm, sensor_mean_ff};
      end
   end

endmodule
`default_nettype wire

>>> src/iqm_ctrl.sv
// Controller: frame position counter and the state machine that sequences
// the sort readout, the two divisions and the result hand-over. Uses iqm_pkg.
`default_nettype none
module iqm_ctrl #(
   parameter int SENSOR_SAMPLES = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output iqm_pkg::dp_cmd_type         cmd,
   input  wire iqm_pkg::dp_status_type status
);
   import iqm_pkg::*;

   localparam int FRAME_LEN = SENSOR_SAMPLES + 2 * GROUP_SAMPLES;
   localparam int CNT_W = $clog2(FRAME_LEN);
   localparam int LO = SENSOR_SAMPLES / 4;
   localparam int HI = 3 * SENSOR_SAMPLES / 4;

   typedef enum logic [3:0] {
      ST_COLLECT, ST_DRAIN, ST_PREP, ST_T_GO, ST_T_WAIT,
      ST_V_GO, ST_V_WAIT, ST_MUL, ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_tready = (state_ff == ST_COLLECT);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.div_sel  = DIV_SEL_TEMP;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               cmd.insert   = (int'(idx_ff) < SENSOR_SAMPLES);
               cmd.acc_temp = (int'(idx_ff) >= SENSOR_SAMPLES)
                           && (int'(idx_ff) < SENSOR_SAMPLES + GROUP_SAMPLES);
               cmd.acc_ref  = (int'(idx_ff) >= SENSOR_SAMPLES + GROUP_SAMPLES);
               idx_in = CNT_W'(idx_ff + 1'b1);
               if (int'(idx_ff) == FRAME_LEN - 1) begin
                  idx_in   = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            cmd.shift  = 1'b1;
            cmd.sum_en = (int'(idx_ff) >= LO) && (int'(idx_ff) < HI);
            idx_in = CNT_W'(idx_ff + 1'b1);
            if (int'(idx_ff) == SENSOR_SAMPLES - 1) begin
               idx_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_T_GO;
         end
         ST_T_GO: begin
            cmd.div_sel   = DIV_SEL_TEMP;
            cmd.div_start = 1'b1;
            state_in      = ST_T_WAIT;
         end
         ST_T_WAIT: if (status.div_done) state_in = ST_V_GO;
         ST_V_GO: begin
            cmd.div_sel   = DIV_SEL_VOLT;
            cmd.div_start = 1'b1;
            state_in      = ST_V_WAIT;
         end
         ST_V_WAIT: if (status.div_done) state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_div_in_collect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COLLECT) |-> !status.div_done)
      else $error("Divider finished while collecting samples.");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("Result loaded without raising valid.");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(idx_ff) < FRAME_LEN)
      else $error("Frame position out of range.");
`endif

endmodule
`default_nettype wire
